// ===== rtl/core/car_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the chromatic aberration remap unit.
// Depends on nothing; the top level takes everything here by scoped names.
package car_pkg;

	// Fixed field and register widths.
	localparam int COORD_W   = 9;   // coordinates and frame sizes
	localparam int SIZE_W    = 10;  // scaled channel sizes
	localparam int NUM_W     = 19;  // (pos + offset) * frame size
	localparam int DIV_STEPS = 9;   // quotient bits, one per divider step
	localparam int CNT_W     = 4;
	localparam int CFG_IW    = 3;
	localparam int CFG_DW    = 10;

	// Register indexes on the write port.
	localparam logic [CFG_IW-1:0] REG_FRAME_WIDTH   = 3'd0;
	localparam logic [CFG_IW-1:0] REG_FRAME_HEIGHT  = 3'd1;
	localparam logic [CFG_IW-1:0] REG_GREEN_WIDTH   = 3'd2;
	localparam logic [CFG_IW-1:0] REG_GREEN_HEIGHT  = 3'd3;
	localparam logic [CFG_IW-1:0] REG_BLUE_WIDTH    = 3'd4;
	localparam logic [CFG_IW-1:0] REG_BLUE_HEIGHT   = 3'd5;

	// Operation codes.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	// Reset values of the registers.
	localparam logic [COORD_W-1:0] RST_FRAME_SIZE = 9'd256;
	localparam logic [SIZE_W-1:0]  RST_GREEN_SIZE = 10'd260;
	localparam logic [SIZE_W-1:0]  RST_BLUE_SIZE  = 10'd267;

	typedef struct packed {
		logic       op;
		logic [7:0] pos_x;
		logic [7:0] pos_y;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} car_item_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
	} car_result_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_RD_RED,
		S_RD_GRN,
		S_RD_BLU,
		S_DONE
	} car_state_t;

endpackage

// ===== rtl/core/chromatic_aberration_remap_unit.sv =====
`timescale 1ns / 1ps
// Top level of the chromatic aberration remap unit: pixel store, sequencer and
// the shared divider. Depends on car_pkg.
//
// A load word is taken without raising busy, so loads may follow each other on
// every cycle. A read word keeps busy high until the sequencer returns to idle, and
// its result strobes from a register set in S_DONE, in the cycle in which the next
// word may already be accepted. A read uses the one shared restoring divider,
// which needs a product step and 9 subtract steps for each of the four source
// coordinates, followed by three reads of the single pixel store port. Results
// cannot be held off: result_valid is high for exactly one cycle per read. The
// store is not cleared at reset; read only pixels that have been loaded.
module chromatic_aberration_remap_unit #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  car_pkg::car_item_t             item,
	input  logic                           cfg_we,
	input  logic [car_pkg::CFG_IW-1:0]     cfg_idx,
	input  logic [car_pkg::CFG_DW-1:0]     cfg_data,
	output logic                           result_valid,
	output car_pkg::car_result_t           result
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int W_LIM = (MAX_WIDTH < 511) ? MAX_WIDTH : 511;
	localparam int H_LIM = (MAX_HEIGHT < 511) ? MAX_HEIGHT : 511;

	localparam int CW = car_pkg::COORD_W;
	localparam int SW = car_pkg::SIZE_W;
	localparam int NW = car_pkg::NUM_W;

	// Configuration registers.
	logic [CW-1:0] frame_width_q, frame_height_q;
	logic [SW-1:0] green_width_q, green_height_q, blue_width_q, blue_height_q;

	// Control state.
	car_pkg::car_state_t state_q, state_d;
	logic [car_pkg::CNT_W-1:0] cnt_q;
	logic [1:0] sel_q;
	logic       valid_q;

	// Payload registers.
	logic [CW-1:0] x_q, y_q;
	logic [CW-1:0] coord_q [0:3];
	logic [SW-1:0] rem_q, div_q;
	logic [car_pkg::DIV_STEPS-1:0] low_q;
	car_pkg::car_result_t res_q;
	logic [23:0] rdata_q;

	logic [23:0] mem [0:DEPTH-1];

	// Combinational signals.
	logic [CW-1:0] w_eff, h_eff, x_clamp, y_clamp;
	logic          accept, accept_read, wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [CW-1:0] pos_sel, n_sel;
	logic [SW-1:0] s_raw, s_eff, n_ext;
	logic [CW-1:0] offset;
	logic [SW-1:0] sum;
	logic [NW-1:0] product;
	logic [SW:0]   cand;
	logic          ge;
	logic [SW-1:0] rem_next;
	logic          div_last;

	function automatic logic [AW-1:0] pix_addr(input logic [CW-1:0] cx,
	                                           input logic [CW-1:0] cy);
		logic [31:0] a;
		a = 32'(cy) * 32'(MAX_WIDTH) + 32'(cx);
		return a[AW-1:0];
	endfunction

	// Effective frame size: zero counts as one, and the size saturates at the store.
	always_comb begin
		if (frame_width_q == '0)
			w_eff = CW'(1);
		else if (32'(frame_width_q) > 32'(W_LIM))
			w_eff = CW'(W_LIM);
		else
			w_eff = frame_width_q;
		if (frame_height_q == '0)
			h_eff = CW'(1);
		else if (32'(frame_height_q) > 32'(H_LIM))
			h_eff = CW'(H_LIM);
		else
			h_eff = frame_height_q;
	end

	assign x_clamp = ({1'b0, item.pos_x} >= w_eff) ? w_eff - CW'(1) : {1'b0, item.pos_x};
	assign y_clamp = ({1'b0, item.pos_y} >= h_eff) ? h_eff - CW'(1) : {1'b0, item.pos_y};

	assign accept      = start && !busy;
	assign accept_read = accept && (item.op == car_pkg::OP_READ);
	assign wr_en       = accept && (item.op == car_pkg::OP_LOAD) &&
	                     ({1'b0, item.pos_x} < w_eff) && ({1'b0, item.pos_y} < h_eff);
	assign wr_addr     = pix_addr({1'b0, item.pos_x}, {1'b0, item.pos_y});

	// Operands of the coordinate being worked on: green x, green y, blue x, blue y.
	always_comb begin
		case (sel_q)
			2'd0: begin
				pos_sel = x_q;  n_sel = w_eff;  s_raw = green_width_q;
			end
			2'd1: begin
				pos_sel = y_q;  n_sel = h_eff;  s_raw = green_height_q;
			end
			2'd2: begin
				pos_sel = x_q;  n_sel = w_eff;  s_raw = blue_width_q;
			end
			default: begin
				pos_sel = y_q;  n_sel = h_eff;  s_raw = blue_height_q;
			end
		endcase
	end

	// Scaled size is raised to at least the frame size; the numerator is below s * 2^9, so
	// nine quotient bits suffice.
	assign n_ext   = {1'b0, n_sel};
	assign s_eff   = (s_raw < n_ext) ? n_ext : s_raw;
	assign offset  = CW'((s_eff - n_ext) >> 1);
	assign sum     = {1'b0, pos_sel} + {1'b0, offset};
	assign product = NW'(sum) * NW'(n_sel);

	// One restoring divider step.
	assign cand     = {rem_q, low_q[car_pkg::DIV_STEPS-1]};
	assign ge       = cand >= {1'b0, div_q};
	assign rem_next = ge ? SW'(cand - {1'b0, div_q}) : cand[SW-1:0];
	assign div_last = (cnt_q == car_pkg::CNT_W'(car_pkg::DIV_STEPS - 1));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			car_pkg::S_IDLE:   if (accept_read) state_d = car_pkg::S_MUL;
			car_pkg::S_MUL:    state_d = car_pkg::S_DIV;
			car_pkg::S_DIV: begin
				if (div_last)
					state_d = (sel_q == 2'd3) ? car_pkg::S_RD_RED : car_pkg::S_MUL;
			end
			car_pkg::S_RD_RED: state_d = car_pkg::S_RD_GRN;
			car_pkg::S_RD_GRN: state_d = car_pkg::S_RD_BLU;
			car_pkg::S_RD_BLU: state_d = car_pkg::S_DONE;
			car_pkg::S_DONE:   state_d = car_pkg::S_IDLE;
			default:           state_d = car_pkg::S_IDLE;
		endcase
	end

	// Outputs of the sequencer: busy and the store read port.
	always_comb begin
		busy    = 1'b1;
		rd_en   = 1'b0;
		rd_addr = pix_addr(x_q, y_q);
		case (state_q)
			car_pkg::S_IDLE:   busy = 1'b0;
			car_pkg::S_RD_RED: rd_en = 1'b1;
			car_pkg::S_RD_GRN: begin
				rd_en   = 1'b1;
				rd_addr = pix_addr(coord_q[0], coord_q[1]);
			end
			car_pkg::S_RD_BLU: begin
				rd_en   = 1'b1;
				rd_addr = pix_addr(coord_q[2], coord_q[3]);
			end
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= car_pkg::S_IDLE;
			cnt_q   <= '0;
			sel_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= (state_q == car_pkg::S_DONE);
			if (accept_read)
				sel_q <= '0;
			else if (state_q == car_pkg::S_DIV && div_last)
				sel_q <= sel_q + 2'd1;
			if (state_q == car_pkg::S_DIV)
				cnt_q <= div_last ? '0 : cnt_q + car_pkg::CNT_W'(1);
			else
				cnt_q <= '0;
		end
	end

	// Configuration registers; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= car_pkg::RST_FRAME_SIZE;
			frame_height_q <= car_pkg::RST_FRAME_SIZE;
			green_width_q  <= car_pkg::RST_GREEN_SIZE;
			green_height_q <= car_pkg::RST_GREEN_SIZE;
			blue_width_q   <= car_pkg::RST_BLUE_SIZE;
			blue_height_q  <= car_pkg::RST_BLUE_SIZE;
		end else if (cfg_we) begin
			case (cfg_idx)
				car_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[CW-1:0];
				car_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data[CW-1:0];
				car_pkg::REG_GREEN_WIDTH:  green_width_q  <= cfg_data;
				car_pkg::REG_GREEN_HEIGHT: green_height_q <= cfg_data;
				car_pkg::REG_BLUE_WIDTH:   blue_width_q   <= cfg_data;
				car_pkg::REG_BLUE_HEIGHT:  blue_height_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept_read) begin
			x_q <= x_clamp;
			y_q <= y_clamp;
		end
		case (state_q)
			car_pkg::S_MUL: begin
				rem_q <= product[NW-1:car_pkg::DIV_STEPS];
				low_q <= product[car_pkg::DIV_STEPS-1:0];
				div_q <= s_eff;
			end
			car_pkg::S_DIV: begin
				rem_q <= rem_next;
				low_q <= {low_q[car_pkg::DIV_STEPS-2:0], ge};
				if (div_last)
					coord_q[sel_q] <= {low_q[car_pkg::DIV_STEPS-2:0], ge};
			end
			car_pkg::S_RD_GRN: res_q.red_out   <= rdata_q[23:16];
			car_pkg::S_RD_BLU: res_q.green_out <= rdata_q[15:8];
			car_pkg::S_DONE:   res_q.blue_out  <= rdata_q[7:0];
			default: ;
		endcase
	end

	// Pixel store: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= {item.red_in, item.green_in, item.blue_in};
		if (rd_en)
			rdata_q <= mem[rd_addr];
	end

	assign result_valid = valid_q;
	assign result       = res_q;

	// A result word only ever follows the last sequencer state.
	a_valid_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q == car_pkg::S_DONE))
		else $error("result strobe without a finished read");

	// An accepted word never produces a result on the next edge.
	a_no_result_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !result_valid)
		else $error("result strobe right after an accepted word");

	// The partial remainder stays below the divisor.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == car_pkg::S_DIV) |-> (rem_q < div_q))
		else $error("divider remainder out of range");

	// The step counter never runs past the quotient width.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == car_pkg::S_DIV) |-> (cnt_q < car_pkg::CNT_W'(car_pkg::DIV_STEPS)))
		else $error("divider step counter overran");

	// Finishing a read frees the block and strobes in the same cycle.
	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == car_pkg::S_DONE) |=> (result_valid && !busy))
		else $error("read did not complete as expected");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for chromatic_aberration_remap_unit: a directed table, then random
// configurations with load and read words; each result is checked against its table pixel or a local predictor.
// Depends on car_pkg and the unit's RTL only.
module tb;

	localparam int MAX_W           = 256;
	localparam int MAX_H           = 256;
	localparam int STALL_LIMIT     = 2000;
	localparam int N_PHASES        = 8;
	localparam int ITEMS_PER_PHASE = 28;
	localparam int SETTLE_CYCLES   = 4;
	localparam int TAIL_CYCLES     = 60;

	// Indexes past the register list; writes to them must change nothing.
	localparam logic [car_pkg::CFG_IW-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [car_pkg::CFG_IW-1:0] REG_SPARE_HI = 3'd7;

	typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

	typedef struct packed {
		row_kind_t                  kind;
		logic [car_pkg::CFG_IW-1:0] idx;
		logic [car_pkg::CFG_DW-1:0] data;
		car_pkg::car_item_t         w;
		logic                       typed;
		car_pkg::car_result_t       want;
	} row_t;

	// Clamped output position and the green and blue source positions of one read.
	typedef struct packed {
		int rx;
		int ry;
		int gx;
		int gy;
		int bx;
		int by;
	} src_t;

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	car_pkg::car_item_t         item;
	logic                       cfg_we;
	logic [car_pkg::CFG_IW-1:0] cfg_idx;
	logic [car_pkg::CFG_DW-1:0] cfg_data;
	logic                       result_valid;
	car_pkg::car_result_t       result;

	// Predictor state: register copies and the pixel store with its written flags.
	logic [8:0]  frame_w = car_pkg::RST_FRAME_SIZE;
	logic [8:0]  frame_h = car_pkg::RST_FRAME_SIZE;
	logic [9:0]  grn_w   = car_pkg::RST_GREEN_SIZE;
	logic [9:0]  grn_h   = car_pkg::RST_GREEN_SIZE;
	logic [9:0]  blu_w   = car_pkg::RST_BLUE_SIZE;
	logic [9:0]  blu_h   = car_pkg::RST_BLUE_SIZE;
	logic [23:0] pix_mem   [MAX_W*MAX_H];
	bit          pix_known [MAX_W*MAX_H];

	car_pkg::car_result_t out_pixels_q[$];
	row_t        dir_rows[$];
	int          mismatches = 0;
	int          res_cnt = 0;
	int          stall_cnt = 0;

	chromatic_aberration_remap_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result       (result)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic int eff_size(int v, int max);
		if (v < 1)
			return 1;
		if (v > max)
			return max;
		return v;
	endfunction

	function automatic int remap_coord(int pos, int n, int s);
		if (s < n)
			s = n;
		return ((pos + (s - n) / 2) * n) / s;
	endfunction

	function automatic src_t source_coords(int x, int y);
		src_t s;
		int   w;
		int   h;
		w = eff_size(frame_w, MAX_W);
		h = eff_size(frame_h, MAX_H);
		if (x >= w)
			x = w - 1;
		if (y >= h)
			y = h - 1;
		s.rx = x;
		s.ry = y;
		s.gx = remap_coord(x, w, grn_w);
		s.gy = remap_coord(y, h, grn_h);
		s.bx = remap_coord(x, w, blu_w);
		s.by = remap_coord(y, h, blu_h);
		return s;
	endfunction

	// Applies one accepted word to the store; returns 1 with the pixel when a read.
	function automatic bit remap_word(input car_pkg::car_item_t w,
	                                  output car_pkg::car_result_t px);
		src_t s;
		int   a;
		px = '0;
		if (w.op == car_pkg::OP_LOAD) begin
			if (w.pos_x < eff_size(frame_w, MAX_W) && w.pos_y < eff_size(frame_h, MAX_H)) begin
				a = w.pos_y * MAX_W + w.pos_x;
				pix_mem[a] = {w.red_in, w.green_in, w.blue_in};
				pix_known[a] = 1'b1;
			end
			return 1'b0;
		end
		s = source_coords(w.pos_x, w.pos_y);
		px.red_out   = pix_mem[s.ry * MAX_W + s.rx][23:16];
		px.green_out = pix_mem[s.gy * MAX_W + s.gx][15:8];
		px.blue_out  = pix_mem[s.by * MAX_W + s.bx][7:0];
		return 1'b1;
	endfunction

	function automatic logic [car_pkg::CFG_DW-1:0] pick_frame();
		case (int'($urandom_range(0, 9)))
			0: return 10'd256;
			1: return 10'd1;
			2: return $urandom_range(0, 1) ? 10'd0 : 10'($urandom_range(257, 511));
			default: return 10'($urandom_range(2, 255));
		endcase
	endfunction

	function automatic logic [car_pkg::CFG_DW-1:0] pick_scaled(int n);
		int s;
		case (int'($urandom_range(0, 9)))
			0: s = $urandom_range(0, 1023);
			1: s = $urandom_range(0, n);
			2: s = 1023;
			default: s = n + $urandom_range(1, n / 8 + 3);
		endcase
		if (s > 1023)
			s = 1023;
		return 10'(s);
	endfunction

	function automatic row_t cfg_row(logic [car_pkg::CFG_IW-1:0] idx, int data);
		row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.idx = idx;
		r.data = 10'(data);
		return r;
	endfunction

	// For a load px is the pixel written; for a typed read it is the pixel expected.
	function automatic row_t word_row(logic op, int x, int y, logic typed, logic [23:0] px);
		row_t r;
		r = '0;
		r.kind = ROW_WORD;
		r.w.op = op;
		r.w.pos_x = 8'(x);
		r.w.pos_y = 8'(y);
		{r.w.red_in, r.w.green_in, r.w.blue_in} = px;
		r.typed = typed;
		r.want = px;
		return r;
	endfunction

	task automatic report_mismatch(string what);
		$display("[%0t] MISMATCH: %s", $time, what);
		mismatches++;
	endtask

	// Holds start high until the word is taken; start stays high on return.
	task automatic send_word(car_pkg::car_item_t w, logic typed, car_pkg::car_result_t want);
		car_pkg::car_result_t px;
		cfg_we <= 1'b0;
		item <= w;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		if (remap_word(w, px))
			out_pixels_q.push_back(typed ? want : px);
	endtask

	task automatic fill_pixel(int px, int py);
		car_pkg::car_item_t w;
		if (!pix_known[py * MAX_W + px]) begin
			w.op = car_pkg::OP_LOAD;
			w.pos_x = 8'(px);
			w.pos_y = 8'(py);
			w.red_in = 8'($urandom_range(0, 255));
			w.green_in = 8'($urandom_range(0, 255));
			w.blue_in = 8'($urandom_range(0, 255));
			send_word(w, 1'b0, '0);
		end
	endtask

	// A read is only sent once every pixel it samples has been loaded.
	task automatic send_read(int x, int y, logic typed, car_pkg::car_result_t want);
		src_t               s;
		car_pkg::car_item_t w;
		s = source_coords(x, y);
		fill_pixel(s.rx, s.ry);
		fill_pixel(s.gx, s.gy);
		fill_pixel(s.bx, s.by);
		w.op = car_pkg::OP_READ;
		w.pos_x = 8'(x);
		w.pos_y = 8'(y);
		w.red_in = 8'($urandom_range(0, 255));
		w.green_in = 8'($urandom_range(0, 255));
		w.blue_in = 8'($urandom_range(0, 255));
		send_word(w, typed, want);
	endtask

	task automatic idle_gap(int n);
		start <= 1'b0;
		cfg_we <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic quiesce();
		start <= 1'b0;
		cfg_we <= 1'b0;
		while (out_pixels_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Leaves cfg_we high so back-to-back writes need no second assignment in one step.
	task automatic write_reg(logic [car_pkg::CFG_IW-1:0] idx,
	                         logic [car_pkg::CFG_DW-1:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			car_pkg::REG_FRAME_WIDTH:  frame_w = data[8:0];
			car_pkg::REG_FRAME_HEIGHT: frame_h = data[8:0];
			car_pkg::REG_GREEN_WIDTH:  grn_w = data;
			car_pkg::REG_GREEN_HEIGHT: grn_h = data;
			car_pkg::REG_BLUE_WIDTH:   blu_w = data;
			car_pkg::REG_BLUE_HEIGHT:  blu_h = data;
			default: ;
		endcase
	endtask

	always @(posedge clk) begin : result_check
		car_pkg::car_result_t ref_px;
		if (arst_n && result_valid === 1'b1) begin
			res_cnt++;
			if (out_pixels_q.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with no read pending", res_cnt));
			end else begin
				ref_px = out_pixels_q.pop_front();
				if (result.red_out !== ref_px.red_out)
					report_mismatch($sformatf("result %0d red_out %h, predicted %h",
						res_cnt, result.red_out, ref_px.red_out));
				if (result.green_out !== ref_px.green_out)
					report_mismatch($sformatf("result %0d green_out %h, predicted %h",
						res_cnt, result.green_out, ref_px.green_out));
				if (result.blue_out !== ref_px.blue_out)
					report_mismatch($sformatf("result %0d blue_out %h, predicted %h",
						res_cnt, result.blue_out, ref_px.blue_out));
			end
		end
	end

	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || result_valid === 1'b1 || cfg_we === 1'b1)
			stall_cnt = 0;
		else
			stall_cnt++;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("[%0t] no word moved for %0d cycles", $time, STALL_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : stimulus
		row_t               rw;
		car_pkg::car_item_t lw;
		logic               in_cfg;
		int                 ph;
		int                 k;
		int                 rd_pct;
		int                 gap_pct;
		int                 w_eff;
		int                 h_eff;
		int                 x;
		int                 y;

		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// One read under the reset sizes, then all scaled sizes below the frame so that
		// every channel samples the read position itself.
		dir_rows.push_back(word_row(car_pkg::OP_READ, 10, 10, 1'b0, 24'h0));
		dir_rows.push_back(cfg_row(car_pkg::REG_FRAME_WIDTH, 256));
		dir_rows.push_back(cfg_row(car_pkg::REG_FRAME_HEIGHT, 256));
		dir_rows.push_back(cfg_row(car_pkg::REG_GREEN_WIDTH, 0));
		dir_rows.push_back(cfg_row(car_pkg::REG_GREEN_HEIGHT, 5));
		dir_rows.push_back(cfg_row(car_pkg::REG_BLUE_WIDTH, 100));
		dir_rows.push_back(cfg_row(car_pkg::REG_BLUE_HEIGHT, 255));
		dir_rows.push_back(cfg_row(REG_SPARE_LO, 10'h3FF));
		dir_rows.push_back(cfg_row(REG_SPARE_HI, 1));
		dir_rows.push_back(word_row(car_pkg::OP_LOAD, 0, 0, 1'b0, 24'h112233));
		dir_rows.push_back(word_row(car_pkg::OP_READ, 0, 0, 1'b1, 24'h112233));
		dir_rows.push_back(word_row(car_pkg::OP_LOAD, 255, 255, 1'b0, 24'hFFFFFF));
		dir_rows.push_back(word_row(car_pkg::OP_READ, 255, 255, 1'b1, 24'hFFFFFF));
		dir_rows.push_back(word_row(car_pkg::OP_LOAD, 255, 0, 1'b0, 24'h00FF00));
		dir_rows.push_back(word_row(car_pkg::OP_READ, 255, 0, 1'b1, 24'h00FF00));
		dir_rows.push_back(word_row(car_pkg::OP_LOAD, 0, 255, 1'b0, 24'hA55AC3));
		dir_rows.push_back(word_row(car_pkg::OP_READ, 0, 255, 1'b1, 24'hA55AC3));
		dir_rows.push_back(word_row(car_pkg::OP_LOAD, 0, 0, 1'b0, 24'h000000));
		dir_rows.push_back(word_row(car_pkg::OP_READ, 0, 0, 1'b1, 24'h000000));
		// Tiny frame with zero scaled sizes: loads outside are dropped, reads are clamped.
		dir_rows.push_back(cfg_row(car_pkg::REG_FRAME_WIDTH, 3));
		dir_rows.push_back(cfg_row(car_pkg::REG_FRAME_HEIGHT, 2));
		dir_rows.push_back(cfg_row(car_pkg::REG_GREEN_WIDTH, 0));
		dir_rows.push_back(cfg_row(car_pkg::REG_GREEN_HEIGHT, 0));
		dir_rows.push_back(cfg_row(car_pkg::REG_BLUE_WIDTH, 0));
		dir_rows.push_back(cfg_row(car_pkg::REG_BLUE_HEIGHT, 0));
		dir_rows.push_back(word_row(car_pkg::OP_LOAD, 5, 0, 1'b0, 24'hEEEEEE));
		dir_rows.push_back(word_row(car_pkg::OP_LOAD, 2, 0, 1'b0, 24'h123456));
		dir_rows.push_back(word_row(car_pkg::OP_READ, 5, 0, 1'b1, 24'h123456));
		dir_rows.push_back(word_row(car_pkg::OP_LOAD, 1, 2, 1'b0, 24'h777777));
		dir_rows.push_back(word_row(car_pkg::OP_LOAD, 2, 1, 1'b0, 24'h9ABCDE));
		dir_rows.push_back(word_row(car_pkg::OP_READ, 200, 9, 1'b1, 24'h9ABCDE));
		// A zero width counts as one column and an oversized height as the maximum.
		dir_rows.push_back(cfg_row(car_pkg::REG_FRAME_WIDTH, 0));
		dir_rows.push_back(cfg_row(car_pkg::REG_FRAME_HEIGHT, 300));
		dir_rows.push_back(word_row(car_pkg::OP_LOAD, 1, 7, 1'b0, 24'h444444));
		dir_rows.push_back(word_row(car_pkg::OP_LOAD, 0, 7, 1'b0, 24'h3C5A69));
		dir_rows.push_back(word_row(car_pkg::OP_READ, 9, 7, 1'b1, 24'h3C5A69));
		dir_rows.push_back(cfg_row(car_pkg::REG_FRAME_WIDTH, 511));
		dir_rows.push_back(cfg_row(car_pkg::REG_FRAME_HEIGHT, 0));
		dir_rows.push_back(word_row(car_pkg::OP_READ, 255, 40, 1'b1, 24'h00FF00));
		// Large shifts, up to the largest scaled width, checked by the predictor.
		dir_rows.push_back(cfg_row(car_pkg::REG_FRAME_WIDTH, 256));
		dir_rows.push_back(cfg_row(car_pkg::REG_FRAME_HEIGHT, 256));
		dir_rows.push_back(cfg_row(car_pkg::REG_GREEN_WIDTH, 512));
		dir_rows.push_back(cfg_row(car_pkg::REG_GREEN_HEIGHT, 512));
		dir_rows.push_back(cfg_row(car_pkg::REG_BLUE_WIDTH, 1023));
		dir_rows.push_back(cfg_row(car_pkg::REG_BLUE_HEIGHT, 257));
		dir_rows.push_back(word_row(car_pkg::OP_READ, 0, 0, 1'b0, 24'h0));
		dir_rows.push_back(word_row(car_pkg::OP_READ, 255, 255, 1'b0, 24'h0));
		dir_rows.push_back(word_row(car_pkg::OP_READ, 128, 128, 1'b0, 24'h0));
		dir_rows.push_back(word_row(car_pkg::OP_READ, 17, 200, 1'b0, 24'h0));

		in_cfg = 1'b0;
		foreach (dir_rows[i]) begin
			rw = dir_rows[i];
			if (rw.kind == ROW_CFG) begin
				if (!in_cfg)
					quiesce();
				write_reg(rw.idx, rw.data);
			end else if (rw.w.op == car_pkg::OP_READ) begin
				send_read(rw.w.pos_x, rw.w.pos_y, rw.typed, rw.want);
			end else begin
				send_word(rw.w, 1'b0, '0);
			end
			in_cfg = (rw.kind == ROW_CFG);
		end

		for (ph = 0; ph < N_PHASES; ph++) begin
			quiesce();
			write_reg(car_pkg::REG_FRAME_WIDTH, pick_frame());
			write_reg(car_pkg::REG_FRAME_HEIGHT, pick_frame());
			w_eff = eff_size(frame_w, MAX_W);
			h_eff = eff_size(frame_h, MAX_H);
			write_reg(car_pkg::REG_GREEN_WIDTH, pick_scaled(w_eff));
			write_reg(car_pkg::REG_GREEN_HEIGHT, pick_scaled(h_eff));
			write_reg(car_pkg::REG_BLUE_WIDTH, pick_scaled(w_eff));
			write_reg(car_pkg::REG_BLUE_HEIGHT, pick_scaled(h_eff));
			if ($urandom_range(0, 3) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
					10'($urandom_range(0, 1023)));
			rd_pct = $urandom_range(30, 70);
			case (int'($urandom_range(0, 2)))
				0: gap_pct = 0;
				1: gap_pct = 20;
				default: gap_pct = 50;
			endcase
			if (ph == N_PHASES - 1)
				gap_pct = 0;
			for (k = 0; k < ITEMS_PER_PHASE; k++) begin
				// Once in the run the sender holds off until every read has answered.
				if (ph == 2 && k == ITEMS_PER_PHASE / 2)
					quiesce();
				if ($urandom_range(1, 100) <= gap_pct)
					idle_gap($urandom_range(1, 10));
				x = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, w_eff - 1);
				y = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, h_eff - 1);
				if ($urandom_range(1, 100) <= rd_pct) begin
					send_read(x, y, 1'b0, '0);
				end else begin
					lw.op = car_pkg::OP_LOAD;
					lw.pos_x = 8'(x);
					lw.pos_y = 8'(y);
					lw.red_in = 8'($urandom_range(0, 255));
					lw.green_in = 8'($urandom_range(0, 255));
					lw.blue_in = 8'($urandom_range(0, 255));
					send_word(lw, 1'b0, '0);
				end
			end
		end

		quiesce();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
